>>> rtl/lspe_pkg.sv
// lspe_pkg: shared types, constants and register map of the led strip pulse encoder
// no dependencies; imported by every other file of the block

package lspe_pkg;

   // slot geometry
   localparam int MAX_SLOTS     = 4;
   localparam int BITS_PER_SLOT = 8;
   localparam int SLOT_IDX_W    = 2;
   localparam int CODE_W        = 3;
   localparam int WORD_W        = MAX_SLOTS * BITS_PER_SLOT;
   localparam int LEFT_W        = 5;

   // configuration port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register indexes (byte address 4*index)
   typedef enum logic [2:0] {
      REG_SLOT_COUNT      = 3'd0,
      REG_SLOT_COLORS     = 3'd1,
      REG_ONE_HIGH_TICKS  = 3'd2,
      REG_ONE_LOW_TICKS   = 3'd3,
      REG_ZERO_HIGH_TICKS = 3'd4,
      REG_ZERO_LOW_TICKS  = 3'd5
   } csr_index_type;

   // slot codes
   typedef enum logic [CODE_W-1:0] {
      SLOT_WHITE = 3'd0,
      SLOT_RED   = 3'd1,
      SLOT_GREEN = 3'd2,
      SLOT_BLUE  = 3'd3
   } slot_code_type;

   // reset values
   localparam logic [2:0]  RST_SLOT_COUNT      = 3'd3;
   localparam logic [11:0] RST_SLOT_COLORS     = 12'd1122;
   localparam logic [7:0]  RST_ONE_HIGH_TICKS  = 8'd27;
   localparam logic [7:0]  RST_ONE_LOW_TICKS   = 8'd1;
   localparam logic [7:0]  RST_ZERO_HIGH_TICKS = 8'd9;
   localparam logic [7:0]  RST_ZERO_LOW_TICKS  = 8'd17;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [2:0]  slot_count;
      logic [11:0] slot_colors;
      logic [7:0]  one_high_ticks;
      logic [7:0]  one_low_ticks;
      logic [7:0]  zero_high_ticks;
      logic [7:0]  zero_low_ticks;
   } cfg_type;

   // pixel after slot mapping
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [LEFT_W-1:0] left;
      logic              bad;
   } map_type;

   // serializer status for the top level
   typedef struct packed {
      logic busy;
      logic emit;
   } ser_status_type;

endpackage

>>> rtl/lspe_if.sv
// lspe_req_if / lspe_rsp_if: valid-ready channels for pixel words and pulse words
// depends on lspe_pkg

interface lspe_req_if
   import lspe_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_end;

   modport source (output valid, red, green, blue, frame_end, input ready);
   modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

interface lspe_rsp_if
   import lspe_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic       bit_value;
   logic [7:0] high_time;
   logic [7:0] low_time;
   logic       pixel_last;
   logic       frame_last;
   logic       bad_mapping;

   modport source (output valid, bit_value, high_time, low_time, pixel_last, frame_last,
                   bad_mapping, input ready);
   modport sink   (input valid, bit_value, high_time, low_time, pixel_last, frame_last,
                   bad_mapping, output ready);
endinterface

>>> rtl/lspe_csr.sv
// lspe_csr: configuration registers behind an apb-style port
// depends on lspe_pkg

module lspe_csr
   import lspe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_SLOT_COUNT:      cfg_in.slot_count      = csr_pwdata[2:0];
            REG_SLOT_COLORS:     cfg_in.slot_colors     = csr_pwdata[11:0];
            REG_ONE_HIGH_TICKS:  cfg_in.one_high_ticks  = csr_pwdata[7:0];
            REG_ONE_LOW_TICKS:   cfg_in.one_low_ticks   = csr_pwdata[7:0];
            REG_ZERO_HIGH_TICKS: cfg_in.zero_high_ticks = csr_pwdata[7:0];
            REG_ZERO_LOW_TICKS:  cfg_in.zero_low_ticks  = csr_pwdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_count      <= RST_SLOT_COUNT;
         cfg_ff.slot_colors     <= RST_SLOT_COLORS;
         cfg_ff.one_high_ticks  <= RST_ONE_HIGH_TICKS;
         cfg_ff.one_low_ticks   <= RST_ONE_LOW_TICKS;
         cfg_ff.zero_high_ticks <= RST_ZERO_HIGH_TICKS;
         cfg_ff.zero_low_ticks  <= RST_ZERO_LOW_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (index)
         REG_SLOT_COUNT:      csr_prdata = {29'd0, cfg_ff.slot_count};
         REG_SLOT_COLORS:     csr_prdata = {20'd0, cfg_ff.slot_colors};
         REG_ONE_HIGH_TICKS:  csr_prdata = {24'd0, cfg_ff.one_high_ticks};
         REG_ONE_LOW_TICKS:   csr_prdata = {24'd0, cfg_ff.one_low_ticks};
         REG_ZERO_HIGH_TICKS: csr_prdata = {24'd0, cfg_ff.zero_high_ticks};
         REG_ZERO_LOW_TICKS:  csr_prdata = {24'd0, cfg_ff.zero_low_ticks};
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/lspe_slot_map.sv
// lspe_slot_map: reorders a pixel into wire order and checks the slot codes
// depends on lspe_pkg

module lspe_slot_map
   import lspe_pkg::*;
(
   input  cfg_type    cfg,
   input  logic [7:0] red,
   input  logic [7:0] green,
   input  logic [7:0] blue,
   output map_type    map
);

   logic [SLOT_IDX_W-1:0] last_slot;

   // clamp the slot count to 1..MAX_SLOTS, kept as index of the last slot
   always_comb begin
      if (cfg.slot_count == 3'd0) begin
         last_slot = '0;
      end else if (cfg.slot_count > 3'(MAX_SLOTS)) begin
         last_slot = SLOT_IDX_W'(MAX_SLOTS - 1);
      end else begin
         last_slot = SLOT_IDX_W'(cfg.slot_count - 3'd1);
      end
   end

   // pick one byte per slot, slot 0 goes out first
   always_comb begin
      logic [CODE_W-1:0] code;
      logic              used;
      map.word = '0;
      map.bad  = 1'b0;
      map.left = {last_slot, 3'b111};
      for (int s = 0; s < MAX_SLOTS; s++) begin
         code = cfg.slot_colors[CODE_W*s +: CODE_W];
         used = (SLOT_IDX_W'(s) <= last_slot);
         if (used) begin
            case (code)
               SLOT_WHITE: map.word[WORD_W-1-BITS_PER_SLOT*s -: BITS_PER_SLOT] = 8'd0;
               SLOT_RED:   map.word[WORD_W-1-BITS_PER_SLOT*s -: BITS_PER_SLOT] = red;
               SLOT_GREEN: map.word[WORD_W-1-BITS_PER_SLOT*s -: BITS_PER_SLOT] = green;
               SLOT_BLUE:  map.word[WORD_W-1-BITS_PER_SLOT*s -: BITS_PER_SLOT] = blue;
               default:    map.bad = 1'b1;
            endcase
         end
      end
   end

endmodule

>>> rtl/lspe_serializer.sv
// lspe_serializer: shift register that sends one pulse word per bit into an output register
// depends on lspe_pkg, lspe_if

module lspe_serializer
   import lspe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  map_type        map,
   lspe_req_if.sink       req,
   lspe_rsp_if.source     rsp,
   output ser_status_type status
);

   logic              busy_ff, busy_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic              bad_ff, bad_in;
   logic              fe_ff, fe_in;

   logic       out_valid_ff, out_valid_in;
   logic       out_bit_ff, out_bit_in;
   logic [7:0] out_high_ff, out_high_in;
   logic [7:0] out_low_ff, out_low_in;
   logic       out_plast_ff, out_plast_in;
   logic       out_flast_ff, out_flast_in;
   logic       out_bad_ff, out_bad_in;

   logic emit;
   logic last;
   logic load;
   logic cur_bit;

   // handshake decisions
   assign emit      = busy_ff & (~out_valid_ff | rsp.ready);
   assign last      = bad_ff | (left_ff == '0);
   assign req.ready = ~busy_ff | (emit & last);
   assign load      = req.valid & req.ready;
   assign cur_bit   = shift_ff[WORD_W-1];

   // shifter next state
   always_comb begin
      busy_in  = busy_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      bad_in   = bad_ff;
      fe_in    = fe_ff;
      if (load) begin
         busy_in  = 1'b1;
         shift_in = map.word;
         left_in  = map.left;
         bad_in   = map.bad;
         fe_in    = req.frame_end;
      end else if (emit) begin
         busy_in  = ~last;
         shift_in = {shift_ff[WORD_W-2:0], 1'b0};
         left_in  = left_ff - LEFT_W'(1);
      end
   end

   // pulse word for the current bit
   always_comb begin
      out_valid_in = out_valid_ff & ~rsp.ready;
      out_bit_in   = out_bit_ff;
      out_high_in  = out_high_ff;
      out_low_in   = out_low_ff;
      out_plast_in = out_plast_ff;
      out_flast_in = out_flast_ff;
      out_bad_in   = out_bad_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_plast_in = last;
         out_flast_in = last & fe_ff;
         out_bad_in   = bad_ff;
         if (bad_ff) begin
            out_bit_in  = 1'b0;
            out_high_in = 8'd0;
            out_low_in  = 8'd0;
         end else begin
            out_bit_in  = cur_bit;
            out_high_in = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
            out_low_in  = cur_bit ? cfg.one_low_ticks : cfg.zero_low_ticks;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shift_ff     <= shift_in;
      left_ff      <= left_in;
      bad_ff       <= bad_in;
      fe_ff        <= fe_in;
      out_bit_ff   <= out_bit_in;
      out_high_ff  <= out_high_in;
      out_low_ff   <= out_low_in;
      out_plast_ff <= out_plast_in;
      out_flast_ff <= out_flast_in;
      out_bad_ff   <= out_bad_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.bit_value   = out_bit_ff;
   assign rsp.high_time   = out_high_ff;
   assign rsp.low_time    = out_low_ff;
   assign rsp.pixel_last  = out_plast_ff;
   assign rsp.frame_last  = out_flast_ff;
   assign rsp.bad_mapping = out_bad_ff;

   assign status.busy = busy_ff;
   assign status.emit = emit;

endmodule

>>> rtl/led_strip_pulse_encoder_core.sv
// led_strip_pulse_encoder_core: pixel to pulse word encoder for addressable led strips
// a pixel word is loaded into the shift register; each pulse word then passes through the output register
// 8 * slots pulse words per pixel, one per cycle unless rsp ready stalls the output register,
//   a single word for a pixel with a bad slot map; the next pixel is taken on the last bit
// reset: synchronous, clears the shifter busy flag and output valid, loads register defaults
// depends on lspe_pkg, lspe_if, lspe_csr, lspe_slot_map, lspe_serializer

module led_strip_pulse_encoder_core
   import lspe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lspe_req_if.sink              req_bus,
   lspe_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type        cfg;
   map_type        map;
   ser_status_type status;

   // configuration registers
   lspe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // channel reorder in front of the shifter
   lspe_slot_map u_slot_map (
      .cfg   (cfg),
      .red   (req_bus.red),
      .green (req_bus.green),
      .blue  (req_bus.blue),
      .map   (map)
   );

   // bit serializer and output register
   lspe_serializer u_serializer (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .map    (map),
      .req    (req_bus),
      .rsp    (rsp_bus),
      .status (status)
   );

`ifndef SYNTHESIS
   // an accepted pixel always leaves the shifter busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> status.busy)
      else $error("shifter not busy after pixel accept");

   // a bad map result is a single zeroed, pixel-closing word
   a_bad_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.bad_mapping) |->
         (rsp_bus.pixel_last && !rsp_bus.bit_value && rsp_bus.high_time == 8'd0))
      else $error("bad map word malformed");

   // frame end is only flagged on the last word of a pixel
   a_frame_in_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.frame_last) |-> rsp_bus.pixel_last)
      else $error("frame_last without pixel_last");

   // the output register only loads while the shifter holds a pixel
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !$past(rsp_bus.valid)) |-> $past(status.busy))
      else $error("pulse word without a pixel in the shifter");
`endif

endmodule
